// ===== hdl/pts_pkg.sv =====
// shared types, constants and microcode table of the priority thread scheduler
`default_nettype none

package pts_pkg;

   localparam int NSLOTS         = 8;
   localparam int IDX_W          = $clog2(NSLOTS);
   localparam int CNT_W          = $clog2(NSLOTS + 1);
   localparam int PRIO_W         = 8;
   localparam int BEST_W         = PRIO_W + 1;
   localparam int TICK_W         = 16;
   localparam int CMD_W          = 2;
   localparam int CUR_THREAD_W   = 3;
   localparam int THREAD_COUNT_W = 4;
   localparam int REQ_DATA_W     = 24;
   localparam int RSP_DATA_W     = 16;
   localparam int RSP_FIELDS_W   = THREAD_COUNT_W + CUR_THREAD_W + 3;
   localparam int UPC_W          = 3;

   localparam logic [PRIO_W-1:0] IDLE_PRIO   = PRIO_W'(255);
   localparam logic [TICK_W-1:0] SLICE_RESET = TICK_W'(10);
   localparam logic [BEST_W-1:0] BEST_INIT   = BEST_W'(256);

   typedef enum logic [1:0] {
      ST_BLOCKED,
      ST_READY,
      ST_RUNNING,
      ST_SLEEPING
   } entry_state_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE,
      CMD_SCHEDULE,
      CMD_DELAY,
      CMD_TICK
   } command_type;

   typedef enum logic [2:0] {
      OP_CREATE,
      OP_DEMOTE,
      OP_SCAN,
      OP_PICK,
      OP_SLEEP,
      OP_WAKE,
      OP_SLICE
   } uop_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_LOOP,
      SEQ_END
   } seq_type;

   typedef struct packed {
      uop_type op;
      seq_type seq;
   } ucode_word_type;

   typedef struct packed {
      logic    start;
      logic    en;
      logic    last;
      uop_type op;
   } dp_ctrl_type;

   typedef struct packed {
      logic more;
   } dp_status_type;

   localparam logic [UPC_W-1:0] UPC_CREATE = UPC_W'(0);
   localparam logic [UPC_W-1:0] UPC_SCHED  = UPC_W'(1);
   localparam logic [UPC_W-1:0] UPC_SCAN   = UPC_W'(2);
   localparam logic [UPC_W-1:0] UPC_PICK   = UPC_W'(3);
   localparam logic [UPC_W-1:0] UPC_DELAY  = UPC_W'(4);
   localparam logic [UPC_W-1:0] UPC_TICK   = UPC_W'(5);
   localparam logic [UPC_W-1:0] UPC_SLICE  = UPC_W'(6);

   function automatic ucode_word_type ucode_rom(input logic [UPC_W-1:0] upc);
      ucode_word_type word;
      case (upc)
         UPC_CREATE: word = '{op: OP_CREATE, seq: SEQ_END};
         UPC_SCHED:  word = '{op: OP_DEMOTE, seq: SEQ_NEXT};
         UPC_SCAN:   word = '{op: OP_SCAN,   seq: SEQ_LOOP};
         UPC_PICK:   word = '{op: OP_PICK,   seq: SEQ_END};
         UPC_DELAY:  word = '{op: OP_SLEEP,  seq: SEQ_END};
         UPC_TICK:   word = '{op: OP_WAKE,   seq: SEQ_LOOP};
         UPC_SLICE:  word = '{op: OP_SLICE,  seq: SEQ_END};
         default:    word = '{op: OP_SLICE,  seq: SEQ_END};
      endcase
      return word;
   endfunction

   function automatic logic [UPC_W-1:0] dispatch(input command_type cmd);
      logic [UPC_W-1:0] upc;
      case (cmd)
         CMD_CREATE:   upc = UPC_CREATE;
         CMD_SCHEDULE: upc = UPC_SCHED;
         CMD_DELAY:    upc = UPC_DELAY;
         CMD_TICK:     upc = UPC_TICK;
         default:      upc = UPC_TICK;
      endcase
      return upc;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/pts_sequencer.sv =====
// microcode sequencer: step counter, control store, handshakes and result valid
`default_nettype none

module pts_sequencer import pts_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire command_type   req_command,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic               csr_ready,
   input  wire dp_status_type status,
   output dp_ctrl_type        ctrl
);

   logic             busy_ff, busy_in;
   logic [UPC_W-1:0] upc_ff, upc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ucode_word_type   word;
   logic             accept;
   logic             out_free;
   logic             step_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         upc_ff       <= UPC_CREATE;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      word     = ucode_rom(upc_ff);
      accept   = req_tvalid && !busy_ff;
      out_free = !rsp_valid_ff || rsp_tready;
      step_en  = busy_ff && ((word.seq != SEQ_END) || out_free);
      busy_in  = busy_ff;
      upc_in   = upc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         busy_in = 1'b1;
         upc_in  = dispatch(req_command);
      end else if (step_en) begin
         case (word.seq)
            SEQ_NEXT: upc_in = upc_ff + UPC_W'(1);
            SEQ_LOOP: begin
               if (!status.more) begin
                  upc_in = upc_ff + UPC_W'(1);
               end
            end
            SEQ_END: begin
               busy_in      = 1'b0;
               rsp_valid_in = 1'b1;
            end
            default: busy_in = 1'b0;
         endcase
      end
      ctrl.start = accept;
      ctrl.en    = step_en;
      ctrl.last  = step_en && (word.seq == SEQ_END);
      ctrl.op    = word.op;
   end

   assign req_tready = !busy_ff;
   assign csr_ready  = !busy_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hdl/pts_datapath.sv =====
// thread table, scan registers, slice counter and result register
`default_nettype none

module pts_datapath import pts_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dp_ctrl_type           ctrl,
   output dp_status_type              status,
   input  wire logic [PRIO_W-1:0]     req_prio,
   input  wire logic [TICK_W-1:0]     req_dly,
   input  wire logic                  csr_we,
   input  wire logic [TICK_W-1:0]     csr_data,
   output logic [RSP_DATA_W-1:0]      rsp_data
);

   entry_state_type       state_ff [NSLOTS];
   logic [PRIO_W-1:0]     prio_ff  [NSLOTS];
   logic [TICK_W-1:0]     sleep_ff [NSLOTS];

   logic [TICK_W-1:0]     slice_ff, slice_in;
   logic [CNT_W-1:0]      used_ff, used_in;
   logic [IDX_W-1:0]      run_ff, run_in;
   logic                  run_valid_ff, run_valid_in;
   logic [TICK_W-1:0]     timeslice_ff;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      pick_ff, pick_in;
   logic [BEST_W-1:0]     best_ff, best_in;
   logic [PRIO_W-1:0]     prio_arg_ff;
   logic [TICK_W-1:0]     dly_arg_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [IDX_W-1:0]      addr;
   entry_state_type       rd_state, wr_state;
   logic [PRIO_W-1:0]     rd_prio;
   logic [TICK_W-1:0]     rd_sleep, wr_sleep;
   logic                  wr_state_en, wr_prio_en, wr_sleep_en;
   logic                  more;
   logic                  accepted;
   logic                  sw;

   always_comb begin
      case (ctrl.op)
         OP_CREATE: addr = IDX_W'(used_ff);
         OP_SCAN,
         OP_WAKE:   addr = idx_ff;
         OP_PICK:   addr = pick_ff;
         default:   addr = run_ff;
      endcase
   end

   assign rd_state = state_ff[addr];
   assign rd_prio  = prio_ff[addr];
   assign rd_sleep = sleep_ff[addr];
   assign more     = (CNT_W'(idx_ff) + CNT_W'(1)) < used_ff;
   assign status.more = more;

   always_comb begin
      wr_state_en  = 1'b0;
      wr_prio_en   = 1'b0;
      wr_sleep_en  = 1'b0;
      wr_state     = rd_state;
      wr_sleep     = rd_sleep;
      used_in      = used_ff;
      run_in       = run_ff;
      run_valid_in = run_valid_ff;
      slice_in     = slice_ff;
      idx_in       = idx_ff;
      pick_in      = pick_ff;
      best_in      = best_ff;
      accepted     = 1'b1;
      sw           = 1'b0;
      if (ctrl.start) begin
         idx_in  = '0;
         pick_in = '0;
         best_in = BEST_INIT;
      end else if (ctrl.en) begin
         case (ctrl.op)
            OP_CREATE: begin
               if (used_ff >= CNT_W'(NSLOTS)) begin
                  accepted = 1'b0;
               end else begin
                  wr_state_en = 1'b1;
                  wr_prio_en  = 1'b1;
                  wr_sleep_en = 1'b1;
                  wr_state    = ST_READY;
                  wr_sleep    = '0;
                  used_in     = used_ff + CNT_W'(1);
               end
            end
            OP_DEMOTE: begin
               if (run_valid_ff && (rd_state == ST_RUNNING)) begin
                  wr_state_en = 1'b1;
                  wr_state    = ST_READY;
               end
            end
            OP_SCAN: begin
               if ((rd_state == ST_READY) && ({1'b0, rd_prio} < best_ff)) begin
                  best_in = {1'b0, rd_prio};
                  pick_in = idx_ff;
               end
               idx_in = more ? idx_ff + IDX_W'(1) : '0;
            end
            OP_PICK: begin
               wr_state_en  = 1'b1;
               wr_state     = ST_RUNNING;
               run_in       = pick_ff;
               run_valid_in = 1'b1;
               slice_in     = timeslice_ff;
            end
            OP_SLEEP: begin
               if (run_valid_ff) begin
                  wr_state_en = 1'b1;
                  wr_sleep_en = 1'b1;
                  wr_state    = ST_SLEEPING;
                  wr_sleep    = dly_arg_ff;
                  sw          = 1'b1;
               end
            end
            OP_WAKE: begin
               if (rd_state == ST_SLEEPING) begin
                  wr_sleep_en = 1'b1;
                  wr_sleep    = (rd_sleep != '0) ? rd_sleep - TICK_W'(1) : '0;
                  if (wr_sleep == '0) begin
                     wr_state_en = 1'b1;
                     wr_state    = ST_READY;
                  end
               end
               idx_in = more ? idx_ff + IDX_W'(1) : '0;
            end
            OP_SLICE: begin
               if (run_valid_ff) begin
                  slice_in = slice_ff - TICK_W'(1);
                  sw       = (slice_in == '0);
               end
            end
            default: accepted = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSLOTS; i++) begin
            state_ff[i] <= (i == 0) ? ST_READY : ST_BLOCKED;
            prio_ff[i]  <= (i == 0) ? IDLE_PRIO : '0;
            sleep_ff[i] <= '0;
         end
         slice_ff     <= '0;
         used_ff      <= CNT_W'(1);
         run_ff       <= '0;
         run_valid_ff <= 1'b0;
         timeslice_ff <= SLICE_RESET;
         idx_ff       <= '0;
         pick_ff      <= '0;
         best_ff      <= BEST_INIT;
      end else begin
         if (wr_state_en) begin
            state_ff[addr] <= wr_state;
         end
         if (wr_prio_en) begin
            prio_ff[addr] <= prio_arg_ff;
         end
         if (wr_sleep_en) begin
            sleep_ff[addr] <= wr_sleep;
         end
         if (csr_we) begin
            timeslice_ff <= csr_data;
         end
         slice_ff     <= slice_in;
         used_ff      <= used_in;
         run_ff       <= run_in;
         run_valid_ff <= run_valid_in;
         idx_ff       <= idx_in;
         pick_ff      <= pick_in;
         best_ff      <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         prio_arg_ff <= req_prio;
         dly_arg_ff  <= req_dly;
      end
      if (ctrl.last) begin
         rsp_data_ff <= {(RSP_DATA_W - RSP_FIELDS_W)'(0), THREAD_COUNT_W'(used_in), sw,
                         run_valid_in, CUR_THREAD_W'(run_in), accepted};
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hdl/priority_thread_scheduler.sv =====
// top level of the priority thread scheduler
`default_nettype none

// Fixed-priority preemptive thread scheduler with an eight-entry thread table.
// Each request transfer carries one command and produces exactly one response
// transfer. A microcoded sequencer steps through the table one entry per
// cycle, so the number of entries in use (N, 1 to 8) sets the cost of tick
// and schedule, which scan the table; create and delay do not scan it. The
// result sits in an output register, so a new request is taken while a
// response still waits. The timeslice register is written through the csr
// channel while no command is in progress; it resets to 10 ticks.

module priority_thread_scheduler import pts_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // new_priority [7:0], delay_ticks [23:8]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // command [1:0]
   input  wire logic [CMD_W-1:0]      req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // accepted [0], current_thread [3:1], current_valid [4], switch_request [5],
   // thread_count [9:6]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [TICK_W-1:0]     csr_data
);

   dp_ctrl_type   ctrl;
   dp_status_type status;

   pts_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (command_type'(req_tuser)),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_ready   (csr_ready),
      .status      (status),
      .ctrl        (ctrl)
   );

   pts_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .status   (status),
      .req_prio (req_tdata[PRIO_W-1:0]),
      .req_dly  (req_tdata[PRIO_W +: TICK_W]),
      .csr_we   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .rsp_data (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== hdl/pts_checker.sv =====
// port-level assertions for the priority thread scheduler and their bind
`default_nettype none

module pts_checker import pts_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_one_command_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a command is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[9:6] != 4'd0) && (rsp_tdata[9:6] <= 4'(NSLOTS)))
      else $error("thread count out of range");

   a_reject_only_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[9:6] == 4'(NSLOTS))
      else $error("create rejected with room in the table");

   a_no_current: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[4] |-> (rsp_tdata[3:1] == 3'd0) && !rsp_tdata[5])
      else $error("switch or thread index without a current thread");

endmodule

bind priority_thread_scheduler pts_checker u_pts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== tb/sv/priority_thread_scheduler_tb.sv =====
// self-checking testbench of the priority thread scheduler: directed and random command streams
module priority_thread_scheduler_tb;
   import pts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [THREAD_COUNT_W-1:0] thread_count;
      logic                      switch_request;
      logic                      current_valid;
      logic [CUR_THREAD_W-1:0]   current_thread;
      logic                      accepted;
   } sched_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [TICK_W-1:0]     csr_data = '0;

   // scheduler state as the testbench sees it
   entry_state_type   tbl_state [NSLOTS];
   logic [PRIO_W-1:0] tbl_prio [NSLOTS];
   logic [TICK_W-1:0] tbl_sleep [NSLOTS];
   logic [TICK_W-1:0] slice_count;
   logic [TICK_W-1:0] slice_setting;
   int                used_count;
   int                run_idx;
   bit                run_valid;

   sched_result_type sched_expected [$];

   bit no_idle = 1'b0;
   int error_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int switches_seen = 0;
   int rejects_seen = 0;
   int slice_writes = 0;
   int cycle_count = 0;

   priority_thread_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void reset_tables();
      for (int i = 0; i < NSLOTS; i++) begin
         tbl_state[i] = ST_BLOCKED;
         tbl_prio[i]  = '0;
         tbl_sleep[i] = '0;
      end
      tbl_state[0]  = ST_READY;
      tbl_prio[0]   = 8'd255;
      slice_count   = '0;
      slice_setting = 16'd10;
      used_count    = 1;
      run_idx       = 0;
      run_valid     = 1'b0;
   endfunction

   function automatic sched_result_type predict_step(command_type cmd, logic [PRIO_W-1:0] prio,
                                                     logic [TICK_W-1:0] dly);
      sched_result_type r;
      int best;
      int pick;
      r = '0;
      r.accepted = 1'b1;
      case (cmd)
         CMD_CREATE: begin
            if (used_count >= NSLOTS) begin
               r.accepted = 1'b0;
            end else begin
               tbl_state[used_count] = ST_READY;
               tbl_prio[used_count]  = prio;
               tbl_sleep[used_count] = '0;
               used_count++;
            end
         end
         CMD_SCHEDULE: begin
            if (run_valid && tbl_state[run_idx] == ST_RUNNING) tbl_state[run_idx] = ST_READY;
            best = 256;
            pick = 0;
            for (int i = 0; i < used_count; i++) begin
               if (tbl_state[i] == ST_READY && int'(tbl_prio[i]) < best) begin
                  best = tbl_prio[i];
                  pick = i;
               end
            end
            run_idx         = pick;
            run_valid       = 1'b1;
            tbl_state[pick] = ST_RUNNING;
            slice_count     = slice_setting;
         end
         CMD_DELAY: begin
            if (run_valid) begin
               tbl_state[run_idx] = ST_SLEEPING;
               tbl_sleep[run_idx] = dly;
               r.switch_request   = 1'b1;
            end
         end
         default: begin
            for (int i = 0; i < used_count; i++) begin
               if (tbl_state[i] == ST_SLEEPING) begin
                  if (tbl_sleep[i] != 0) tbl_sleep[i] = tbl_sleep[i] - 1'b1;
                  if (tbl_sleep[i] == 0) tbl_state[i] = ST_READY;
               end
            end
            if (run_valid) begin
               slice_count = slice_count - 1'b1;
               if (slice_count == 0) r.switch_request = 1'b1;
            end
         end
      endcase
      r.current_thread = run_idx[CUR_THREAD_W-1:0];
      r.current_valid  = run_valid;
      r.thread_count   = used_count[THREAD_COUNT_W-1:0];
      return r;
   endfunction

   task automatic send_cmd(command_type cmd, logic [PRIO_W-1:0] prio, logic [TICK_W-1:0] dly);
      while (!no_idle && $urandom_range(0, 99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {dly, prio};
      sched_expected.push_back(predict_step(cmd, prio, dly));
      items_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold the request side until every response is back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sched_expected.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_slice(logic [TICK_W-1:0] value);
      drain_responses();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      slice_setting = value;
      slice_writes++;
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      sched_result_type want;
      sched_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RSP_FIELDS_W-1:0];
         if (sched_expected.size() == 0) begin
            $display("%0t ns: response with nothing expected, expected none, actual %h",
                     $time, rsp_tdata);
            error_count++;
         end else begin
            want = sched_expected.pop_front();
            check_field("accepted", want.accepted, got.accepted);
            check_field("current_thread", want.current_thread, got.current_thread);
            check_field("current_valid", want.current_valid, got.current_valid);
            check_field("switch_request", want.switch_request, got.switch_request);
            check_field("thread_count", want.thread_count, got.thread_count);
            results_checked++;
            if (got.switch_request) switches_seen++;
            if (!got.accepted) rejects_seen++;
         end
      end
      rsp_tready <= no_idle || ($urandom_range(0, 99) >= 24);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  sched_expected.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // delay and tick before any thread was ever scheduled
   task automatic test_no_current();
      send_cmd(CMD_TICK, 8'h00, 16'h0000);
      send_cmd(CMD_DELAY, 8'hff, 16'hffff);
   endtask

   // idle entry alone: zero delay, fallback pick of a sleeping entry, countdown while asleep
   task automatic test_idle_only();
      send_cmd(CMD_SCHEDULE, 8'h00, 16'h0000);
      send_cmd(CMD_DELAY, 8'h00, 16'h0000);
      send_cmd(CMD_SCHEDULE, 8'h00, 16'h0000);
      send_cmd(CMD_DELAY, 8'h00, 16'h0002);
      send_cmd(CMD_TICK, 8'h00, 16'h0000);
      send_cmd(CMD_TICK, 8'h00, 16'h0000);
   endtask

   task automatic test_slice_extremes();
      write_slice(16'd0);
      send_cmd(CMD_SCHEDULE, 8'h00, 16'h0000);
      send_cmd(CMD_TICK, 8'h00, 16'h0000);
      write_slice(16'd1);
      send_cmd(CMD_SCHEDULE, 8'h00, 16'h0000);
      send_cmd(CMD_TICK, 8'h00, 16'h0000);
      write_slice(16'hffff);
      send_cmd(CMD_SCHEDULE, 8'h00, 16'h0000);
      send_cmd(CMD_TICK, 8'h00, 16'h0000);
      write_slice(16'd10);
   endtask

   // fill the table, overflow it, priority ties
   task automatic test_table_fill();
      send_cmd(CMD_CREATE, 8'd0, 16'h0000);
      send_cmd(CMD_CREATE, 8'd255, 16'h0000);
      send_cmd(CMD_CREATE, 8'h55, 16'h0000);
      send_cmd(CMD_CREATE, 8'haa, 16'h0000);
      send_cmd(CMD_CREATE, 8'd5, 16'h0000);
      send_cmd(CMD_CREATE, 8'd5, 16'h0000);
      send_cmd(CMD_CREATE, 8'd200, 16'h0000);
      send_cmd(CMD_CREATE, 8'h33, 16'h0000);
      send_cmd(CMD_SCHEDULE, 8'h00, 16'h0000);
      send_cmd(CMD_DELAY, 8'h00, 16'hffff);
      send_cmd(CMD_SCHEDULE, 8'h00, 16'h0000);
      send_cmd(CMD_DELAY, 8'h00, 16'h0002);
      send_cmd(CMD_SCHEDULE, 8'h00, 16'h0000);
   endtask

   task automatic test_random_mix();
      logic [TICK_W-1:0] settings [7];
      command_type       cmd;
      logic [TICK_W-1:0] dly;
      int                pick;
      settings = '{16'd10, 16'd1, 16'd3, 16'd10, 16'hffff, 16'd0, 16'd7};
      settings[3] = TICK_W'($urandom_range(2, 20));
      for (int phase = 0; phase < 7; phase++) begin
         write_slice(settings[phase]);
         no_idle = (phase == 2);
         for (int n = 0; n < 130; n++) begin
            if (phase == 1 && n == 65) drain_responses();
            pick = $urandom_range(0, 99);
            if (pick < 10) cmd = CMD_CREATE;
            else if (pick < 40) cmd = CMD_SCHEDULE;
            else if (pick < 60) cmd = CMD_DELAY;
            else cmd = CMD_TICK;
            if (cmd == CMD_DELAY) begin
               dly = ($urandom_range(0, 99) < 85) ? TICK_W'($urandom_range(0, 8))
                                                  : TICK_W'($urandom_range(0, 40));
            end else begin
               dly = TICK_W'($urandom);
            end
            send_cmd(cmd, PRIO_W'($urandom_range(0, 255)), dly);
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset_tables();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_no_current();
      test_idle_only();
      test_slice_extremes();
      test_table_fill();
      test_random_mix();
      drain_responses();
      repeat (20) @(posedge clock);
      $display("%0d commands sent, %0d responses checked, %0d timeslice writes", items_sent,
               results_checked, slice_writes);
      $display("%0d switch requests and %0d rejected creates observed", switches_seen,
               rejects_seen);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
